>>> hdl/html_tag_strip_text_stream_core_macros.svh
// Assertion macros for the HTML text stripper.
`ifndef HTML_TAG_STRIP_TEXT_STREAM_CORE_MACROS_SVH
`define HTML_TAG_STRIP_TEXT_STREAM_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define HTSS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("htss assertion failed");

// Next-cycle implication, checked out of reset.
`define HTSS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("htss assertion failed");

`endif

>>> hdl/htss_pkg.sv
// Types, constants and helper functions for the HTML text stripper.
`default_nettype none
package htss_pkg;

    localparam int TAG_NAME_MAX_DEF = 8;
    localparam int QUEUE_DEPTH_DEF  = 4;

    localparam logic [7:0] CHAR_LT       = 8'h3C;
    localparam logic [7:0] CHAR_GT       = 8'h3E;
    localparam logic [7:0] CHAR_SLASH    = 8'h2F;
    localparam logic [7:0] CHAR_SPACE    = 8'h20;
    localparam logic [7:0] CHAR_LBRACE   = 8'h7B;
    localparam logic [7:0] CHAR_LBRACKET = 8'h5B;
    localparam logic [7:0] CHAR_TAB      = 8'h09;
    localparam logic [7:0] CHAR_CR       = 8'h0D;

    // Hidden-mode tag names: first four enter, last four leave.
    localparam int WORD_COUNT = 8;
    localparam int WORD_MAX   = 7;
    localparam logic [8*WORD_MAX-1:0] WORD_TEXT [WORD_COUNT] = '{
        "script", "style", "SCRIPT", "STYLE",
        "/script", "/style", "/SCRIPT", "/STYLE"
    };
    localparam int WORD_LEN [WORD_COUNT] = '{6, 5, 6, 5, 7, 6, 7, 6};

    typedef struct packed {
        logic [7:0] doc_byte;
        logic       doc_last;
    } doc_in_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       byte_valid;
        logic       doc_end;
        logic       run_last;
    } text_out_t;

    // Work handed from the classifier to the emitter.
    typedef struct packed {
        logic [7:0] text_byte;
        logic       emit_space;
        logic       emit_byte;
        logic       emit_end;
    } job_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
    endfunction

    // Character i of word w, zero past its end.
    function automatic logic [7:0] word_char(input int w, input int i);
        logic [7:0] ch;
        ch = 8'h00;
        if (i < WORD_LEN[w]) begin
            ch = WORD_TEXT[w][8*(WORD_LEN[w]-1-i) +: 8];
        end
        return ch;
    endfunction

endpackage
`default_nettype wire

>>> hdl/html_tag_strip_text_stream_core.sv
// HTML visible-text extractor: tag and hidden-block stripping, whitespace collapse.
// One document byte is taken per cycle. The classifier decides in the accept
// cycle what the byte produces and places that job in a QUEUE_DEPTH-entry
// queue; the emitter drives one output transfer per cycle while m_ready is high,
// so a byte that yields a space plus a character, or a character plus the end
// marker, takes two output transfers, and a last byte with a pending space,
// text and end marker takes three. Bytes that yield nothing place no job in
// the queue. A byte's job passes through the queue slot and then the emitter's
// current-job register before its first result can be taken. Input stalls only
// when the queue fills because the output side is slower or stalled.
`default_nettype none
`include "html_tag_strip_text_stream_core_macros.svh"
module html_tag_strip_text_stream_core
    import htss_pkg::*;
#(
    parameter int TAG_NAME_MAX = TAG_NAME_MAX_DEF,
    parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire doc_in_t s_data,
    output logic         m_valid,
    input  wire logic    m_ready,
    output text_out_t    m_data
);

    logic q_full;
    logic q_push;
    job_t q_push_job;
    logic q_head_valid;
    job_t q_head_job;
    logic q_pop;

    htss_front #(
        .TAG_NAME_MAX(TAG_NAME_MAX)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_job   (q_push_job)
    );

    htss_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_job   (q_push_job),
        .full       (q_full),
        .head_valid (q_head_valid),
        .head_job   (q_head_job),
        .pop        (q_pop)
    );

    htss_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_head_valid),
        .q_job   (q_head_job),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    `HTSS_ASSERT_NOW(a_no_push_when_full, q_push, !q_full)
    `HTSS_ASSERT_NOW(a_end_marker_shape, m_valid && m_data.doc_end, !m_data.byte_valid && m_data.run_last)
    `HTSS_ASSERT_NOW(a_nonbyte_is_end, m_valid && !m_data.byte_valid, m_data.doc_end)
    `HTSS_ASSERT_NEXT(a_space_then_byte, m_valid && m_ready && m_data.byte_valid && !m_data.run_last && m_data.text_byte == CHAR_SPACE, m_valid)

endmodule
`default_nettype wire

>>> hdl/htss_front.sv
// Classifier: tracks tag, hidden and whitespace state and issues emit jobs.
`default_nettype none
module htss_front
    import htss_pkg::*;
#(
    parameter int TAG_NAME_MAX = TAG_NAME_MAX_DEF
) (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire doc_in_t s_data,
    input  wire logic    q_full,
    output logic         q_push,
    output job_t         q_job
);

    localparam int LEN_W = $clog2(TAG_NAME_MAX + 1);

    logic             inside_tag_reg,    inside_tag_next;
    logic             hidden_reg,        hidden_next;
    logic [7:0]       name_chars_reg [TAG_NAME_MAX];
    logic [7:0]       name_chars_next [TAG_NAME_MAX];
    logic [LEN_W-1:0] name_len_reg,      name_len_next;
    logic             name_ovf_reg,      name_ovf_next;
    logic             name_done_reg,     name_done_next;
    logic             space_pend_reg,    space_pend_next;
    logic             text_started_reg,  text_started_next;
    logic             first_seen_reg,    first_seen_next;
    logic             json_reg,          json_next;

    logic [WORD_COUNT-1:0] word_hit;
    logic                  enter_hit;
    logic                  leave_hit;
    logic                  fire;
    logic [7:0]            c;
    logic                  c_ws;
    logic                  visible;
    logic                  append;
    logic                  json_now;

    assign s_ready = !q_full;
    assign fire    = s_valid && s_ready;
    assign c       = s_data.doc_byte;
    assign c_ws    = is_ws(c);

    always_comb begin
        for (int w = 0; w < WORD_COUNT; w++) begin
            word_hit[w] = !name_ovf_reg && (name_len_reg == LEN_W'(WORD_LEN[w]));
            for (int i = 0; i < WORD_MAX; i++) begin
                if (name_chars_reg[i] != word_char(w, i)) begin
                    word_hit[w] = 1'b0;
                end
            end
        end
    end

    assign enter_hit = |word_hit[3:0];
    assign leave_hit = |word_hit[7:4];

    always_comb begin
        inside_tag_next   = inside_tag_reg;
        hidden_next       = hidden_reg;
        name_chars_next   = name_chars_reg;
        name_len_next     = name_len_reg;
        name_ovf_next     = name_ovf_reg;
        name_done_next    = name_done_reg;
        space_pend_next   = space_pend_reg;
        text_started_next = text_started_reg;
        first_seen_next   = first_seen_reg;
        json_next         = json_reg;
        visible           = 1'b0;
        append            = 1'b0;

        if (!first_seen_reg && !c_ws) begin
            first_seen_next = 1'b1;
            json_next       = (c == CHAR_LBRACE) || (c == CHAR_LBRACKET);
        end
        // document kind for this byte, before any end-of-document clear
        json_now = json_next;

        if (c == CHAR_LT) begin
            inside_tag_next = 1'b1;
            name_len_next   = '0;
            name_ovf_next   = 1'b0;
            name_done_next  = 1'b0;
            for (int i = 0; i < TAG_NAME_MAX; i++) begin
                name_chars_next[i] = 8'h00;
            end
        end else if (c == CHAR_GT) begin
            inside_tag_next = 1'b0;
            if (enter_hit) begin
                hidden_next = 1'b1;
            end else if (leave_hit) begin
                hidden_next = 1'b0;
            end
            name_len_next = '0;
            name_ovf_next = 1'b0;
            for (int i = 0; i < TAG_NAME_MAX; i++) begin
                name_chars_next[i] = 8'h00;
            end
        end else if (inside_tag_reg) begin
            if (!name_done_reg) begin
                if (c_ws) begin
                    name_done_next = 1'b1;
                end else if (c == CHAR_SLASH && name_len_reg != '0) begin
                    name_done_next = 1'b1;
                end else begin
                    append = 1'b1;
                end
            end
        end else if (!hidden_reg) begin
            if (c_ws) begin
                if (text_started_reg) begin
                    space_pend_next = 1'b1;
                end
            end else begin
                visible           = 1'b1;
                space_pend_next   = 1'b0;
                text_started_next = 1'b1;
            end
        end

        if (append) begin
            if (name_len_reg < LEN_W'(TAG_NAME_MAX)) begin
                for (int i = 0; i < TAG_NAME_MAX; i++) begin
                    if (name_len_reg == LEN_W'(i)) begin
                        name_chars_next[i] = c;
                    end
                end
                name_len_next = name_len_reg + LEN_W'(1);
            end else begin
                name_ovf_next = 1'b1;
            end
        end

        if (s_data.doc_last) begin
            inside_tag_next   = 1'b0;
            hidden_next       = 1'b0;
            name_len_next     = '0;
            name_ovf_next     = 1'b0;
            name_done_next    = 1'b0;
            space_pend_next   = 1'b0;
            text_started_next = 1'b0;
            first_seen_next   = 1'b0;
            json_next         = 1'b0;
            for (int i = 0; i < TAG_NAME_MAX; i++) begin
                name_chars_next[i] = 8'h00;
            end
        end
    end

    always_comb begin
        q_job.text_byte  = c;
        q_job.emit_byte  = visible && !json_now;
        q_job.emit_space = visible && !json_now && space_pend_reg;
        q_job.emit_end   = s_data.doc_last;
        q_push = fire && (q_job.emit_byte || q_job.emit_end);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inside_tag_reg   <= 1'b0;
            hidden_reg       <= 1'b0;
            name_len_reg     <= '0;
            name_ovf_reg     <= 1'b0;
            name_done_reg    <= 1'b0;
            space_pend_reg   <= 1'b0;
            text_started_reg <= 1'b0;
            first_seen_reg   <= 1'b0;
            json_reg         <= 1'b0;
            for (int i = 0; i < TAG_NAME_MAX; i++) begin
                name_chars_reg[i] <= 8'h00;
            end
        end else if (fire) begin
            inside_tag_reg   <= inside_tag_next;
            hidden_reg       <= hidden_next;
            name_len_reg     <= name_len_next;
            name_ovf_reg     <= name_ovf_next;
            name_done_reg    <= name_done_next;
            space_pend_reg   <= space_pend_next;
            text_started_reg <= text_started_next;
            first_seen_reg   <= first_seen_next;
            json_reg         <= json_next;
            name_chars_reg   <= name_chars_next;
        end
    end

endmodule
`default_nettype wire

>>> hdl/htss_queue.sv
// Small job queue between the classifier and the emitter.
`default_nettype none
module htss_queue
    import htss_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire job_t push_job,
    output logic      full,
    output logic      head_valid,
    output job_t      head_job,
    input  wire logic pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

>>> hdl/htss_back.sv
// Emitter: turns each job into its space, text and end-marker transfers.
`default_nettype none
module htss_back
    import htss_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic q_valid,
    input  wire job_t q_job,
    output logic      q_pop,
    output logic      m_valid,
    input  wire logic m_ready,
    output text_out_t m_data
);

    job_t cur_reg,       cur_next;
    logic cur_valid_reg, cur_valid_next;
    job_t rem;
    logic take;
    logic done;
    logic load;

    assign m_valid = cur_valid_reg;
    assign take    = cur_valid_reg && m_ready;

    always_comb begin
        rem = cur_reg;
        if (cur_reg.emit_space) begin
            rem.emit_space = 1'b0;
            m_data.text_byte  = CHAR_SPACE;
            m_data.byte_valid = 1'b1;
            m_data.doc_end    = 1'b0;
        end else if (cur_reg.emit_byte) begin
            rem.emit_byte = 1'b0;
            m_data.text_byte  = cur_reg.text_byte;
            m_data.byte_valid = 1'b1;
            m_data.doc_end    = 1'b0;
        end else begin
            rem.emit_end = 1'b0;
            m_data.text_byte  = 8'h00;
            m_data.byte_valid = 1'b0;
            m_data.doc_end    = 1'b1;
        end
        done = !(rem.emit_space || rem.emit_byte || rem.emit_end);
        m_data.run_last = done;
    end

    always_comb begin
        load           = !cur_valid_reg || (take && done);
        q_pop          = load && q_valid;
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        if (load) begin
            cur_next       = q_job;
            cur_valid_next = q_valid;
        end else if (take) begin
            cur_next = rem;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
        end
    end

endmodule
`default_nettype wire
